// ===== src/clf_pkg.sv =====
// ----------------------------------------------------------------------------
// CR LF command line framer package
// Shared widths, characters, payload types and state codes.
// ----------------------------------------------------------------------------
package clf_pkg;

    localparam int LINE_DEPTH_DEF = 64;
    localparam int BYTE_W         = 8;
    localparam int TICK_W         = 32;
    localparam int TIMEOUT_W      = 16;
    localparam int CMD_LEN_W      = 6;

    localparam logic [BYTE_W-1:0]    CH_LF         = 8'h0A;
    localparam logic [BYTE_W-1:0]    CH_CR         = 8'h0D;
    localparam logic [BYTE_W-1:0]    CH_NUL        = 8'h00;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;

    // Command handed from the front to the back: the number of bytes to read out.
    typedef struct packed {
        logic                 valid;
        logic [CMD_LEN_W-1:0] len;
    } cmd_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    cmd_byte;
        logic                 cmd_last;
        logic [CMD_LEN_W-1:0] cmd_length;
    } cmd_item_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_READ
    } back_state_t;

endpackage

// ===== src/clf_if.sv =====
// ----------------------------------------------------------------------------
// CR LF command line framer channels
// Valid/ready channels for received bytes and for command output.
// ----------------------------------------------------------------------------
interface clf_rx_if;
    logic                            valid;
    logic                            ready;
    logic [clf_pkg::BYTE_W-1:0]      rx_byte;
    logic [clf_pkg::TICK_W-1:0]      now_tick;

    modport source (output valid, output rx_byte, output now_tick, input ready);
    modport sink   (input valid, input rx_byte, input now_tick, output ready);
endinterface

interface clf_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [clf_pkg::BYTE_W-1:0]      cmd_byte;
    logic                            cmd_last;
    logic [clf_pkg::CMD_LEN_W-1:0]   cmd_length;

    modport source (output valid, output cmd_byte, output cmd_last, output cmd_length,
                    input ready);
    modport sink   (input valid, input cmd_byte, input cmd_last, input cmd_length,
                    output ready);
endinterface

// ===== src/clf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module clf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/clf_front.sv =====
// ----------------------------------------------------------------------------
// CR LF framer front end
// Accepts bytes, applies the idle timeout, stores ordinary bytes and
// recognises a completed CR LF command.
// ----------------------------------------------------------------------------
module clf_front #(
    parameter int LINE_DEPTH = clf_pkg::LINE_DEPTH_DEF,
    parameter int AW         = $clog2(LINE_DEPTH)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    clf_rx_if.sink                          rx,
    input  logic                            cfg_we,
    input  logic [clf_pkg::TIMEOUT_W-1:0]   cfg_wdata,
    input  logic                            back_busy,
    output logic                            ram_we,
    output logic [AW-1:0]                   ram_waddr,
    output logic [clf_pkg::BYTE_W-1:0]      ram_wdata,
    output clf_pkg::cmd_req_t               req
);

    localparam logic [AW:0] FULL_MARK = (AW+1)'(LINE_DEPTH - 2);
    localparam logic [AW:0] WRAP_MARK = (AW+1)'(LINE_DEPTH - 1);

    logic [AW-1:0]                  held_reg, held_next;
    logic                           last_cr_reg, last_cr_next;
    logic [clf_pkg::TICK_W-1:0]     prev_tick_reg, prev_tick_next;
    logic [clf_pkg::TIMEOUT_W-1:0]  timeout_reg, timeout_next;

    logic                           accept;
    logic [clf_pkg::TICK_W-1:0]     gap;
    logic                           timed_out;
    logic [AW-1:0]                  held_eff;
    logic                           is_cmd;
    logic                           too_full;
    logic [AW:0]                    held_inc;

    // A new request is taken only once the back end has finished reading the store.
    assign rx.ready = !back_busy;
    assign accept   = rx.valid && rx.ready;

    always_comb
    begin
        gap       = rx.now_tick - prev_tick_reg;
        timed_out = (held_reg != '0) &&
                    (gap > {{(clf_pkg::TICK_W - clf_pkg::TIMEOUT_W){1'b0}}, timeout_reg});
        held_eff  = timed_out ? '0 : held_reg;
        // The flag tracks the newest stored byte, which is valid whenever bytes are held.
        is_cmd    = (held_eff != '0) && (rx.rx_byte == clf_pkg::CH_LF) && last_cr_reg;
        too_full  = {1'b0, held_eff} >= FULL_MARK;
        held_inc  = {1'b0, held_eff} + (AW+1)'(1);
    end

    always_comb
    begin
        held_next      = held_reg;
        last_cr_next   = last_cr_reg;
        prev_tick_next = prev_tick_reg;
        timeout_next   = cfg_we ? cfg_wdata : timeout_reg;
        if (accept)
        begin
            prev_tick_next = rx.now_tick;
            if (is_cmd)
            begin
                held_next = '0;
            end
            else
            begin
                held_next    = (held_inc >= WRAP_MARK) ? '0 : held_inc[AW-1:0];
                last_cr_next = (rx.rx_byte == clf_pkg::CH_CR);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            last_cr_reg   <= 1'b0;
            prev_tick_reg <= '0;
            timeout_reg   <= clf_pkg::TIMEOUT_RESET;
        end
        else
        begin
            held_reg      <= held_next;
            last_cr_reg   <= last_cr_next;
            prev_tick_reg <= prev_tick_next;
            timeout_reg   <= timeout_next;
        end
    end

    assign ram_we    = accept && !is_cmd;
    assign ram_waddr = held_eff;
    assign ram_wdata = rx.rx_byte;

    // The carriage return itself is not part of the command.
    assign req.valid = accept && is_cmd && !too_full;
    assign req.len   = clf_pkg::CMD_LEN_W'(held_eff - AW'(1));

endmodule

// ===== src/clf_back.sv =====
// ----------------------------------------------------------------------------
// CR LF framer back end
// Queues completed commands and streams their stored bytes and terminator
// through a two-entry output buffer.
// ----------------------------------------------------------------------------
module clf_back #(
    parameter int LINE_DEPTH = clf_pkg::LINE_DEPTH_DEF,
    parameter int AW         = $clog2(LINE_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  clf_pkg::cmd_req_t           req,
    output logic                        busy,
    output logic                        ram_re,
    output logic [AW-1:0]               ram_raddr,
    input  logic [clf_pkg::BYTE_W-1:0]  ram_rdata,
    clf_cmd_if.source                   cmd
);

    clf_pkg::back_state_t           state_reg, state_next;

    logic [clf_pkg::CMD_LEN_W-1:0]  q_len_reg [2];
    logic                           q_wr_reg, q_rd_reg;
    logic [1:0]                     q_count_reg;
    logic                           q_pop;

    logic [clf_pkg::CMD_LEN_W-1:0]  cur_len_reg;
    logic [AW-1:0]                  idx_reg;
    logic                           at_end;
    logic                           issue;
    logic                           room;

    logic                           inflight_reg;
    logic                           infl_last_reg;
    logic [clf_pkg::CMD_LEN_W-1:0]  infl_len_reg;

    clf_pkg::cmd_item_t             buf_reg [2];
    clf_pkg::cmd_item_t             push_item;
    logic                           head_reg;
    logic [1:0]                     occ_reg;
    logic                           tail;
    logic                           pop_out;

    assign pop_out = cmd.valid && cmd.ready;
    assign at_end  = clf_pkg::CMD_LEN_W'(idx_reg) == cur_len_reg;
    // A read may start only if its data will find a free buffer slot.
    assign room    = (({1'b0, occ_reg} + {2'b0, inflight_reg}) - {2'b0, pop_out}) < 3'd2;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            clf_pkg::BACK_IDLE:
            begin
                if (q_count_reg != 2'd0)
                begin
                    state_next = clf_pkg::BACK_READ;
                end
            end
            clf_pkg::BACK_READ:
            begin
                if (room && at_end)
                begin
                    state_next = clf_pkg::BACK_IDLE;
                end
            end
            default:
            begin
                state_next = clf_pkg::BACK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop = 1'b0;
        issue = 1'b0;
        case (state_reg)
            clf_pkg::BACK_IDLE:
            begin
                q_pop = (q_count_reg != 2'd0);
            end
            clf_pkg::BACK_READ:
            begin
                issue = room;
            end
            default:
            begin
                q_pop = 1'b0;
                issue = 1'b0;
            end
        endcase
    end

    assign ram_re    = issue && !at_end;
    assign ram_raddr = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= clf_pkg::BACK_IDLE;
            q_wr_reg      <= 1'b0;
            q_rd_reg      <= 1'b0;
            q_count_reg   <= 2'd0;
            idx_reg       <= '0;
            inflight_reg  <= 1'b0;
            head_reg      <= 1'b0;
            occ_reg       <= 2'd0;
        end
        else
        begin
            state_reg    <= state_next;
            inflight_reg <= issue;
            if (req.valid)
            begin
                q_wr_reg <= !q_wr_reg;
            end
            if (q_pop)
            begin
                q_rd_reg <= !q_rd_reg;
                idx_reg  <= '0;
            end
            else if (issue && !at_end)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
            q_count_reg <= q_count_reg + {1'b0, req.valid} - {1'b0, q_pop};
            head_reg    <= head_reg ^ pop_out;
            occ_reg     <= occ_reg + {1'b0, inflight_reg} - {1'b0, pop_out};
        end
    end

    assign tail = head_reg ^ occ_reg[0];

    always_comb
    begin
        push_item.cmd_byte   = infl_last_reg ? clf_pkg::CH_NUL : ram_rdata;
        push_item.cmd_last   = infl_last_reg;
        push_item.cmd_length = infl_len_reg;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            q_len_reg[q_wr_reg] <= req.len;
        end
        if (q_pop)
        begin
            cur_len_reg <= q_len_reg[q_rd_reg];
        end
        if (issue)
        begin
            infl_last_reg <= at_end;
            infl_len_reg  <= cur_len_reg;
        end
        if (inflight_reg)
        begin
            buf_reg[tail] <= push_item;
        end
    end

    assign busy           = (state_reg != clf_pkg::BACK_IDLE) || inflight_reg ||
                            (q_count_reg != 2'd0);
    assign cmd.valid      = (occ_reg != 2'd0);
    assign cmd.cmd_byte   = buf_reg[head_reg].cmd_byte;
    assign cmd.cmd_last   = buf_reg[head_reg].cmd_last;
    assign cmd.cmd_length = buf_reg[head_reg].cmd_length;

    a_buffer_never_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, occ_reg} + {2'b0, inflight_reg}) <= 3'd2)
        else $error("output buffer and read in flight exceed two entries");

    a_request_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> !busy)
        else $error("command request arrived while the back end was busy");

    a_terminator_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.cmd_last) |-> (cmd.cmd_byte == clf_pkg::CH_NUL))
        else $error("terminator result carries a non-zero byte");

endmodule

// ===== src/crlf_command_line_framer_unit.sv =====
// ----------------------------------------------------------------------------
// CR LF command line framer
// Collects received bytes into a line store and emits each CR LF terminated
// command as a stream of bytes followed by a zero terminator.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one received byte with its arrival tick per request. cmd carries
//   one command byte per request, then a zero byte with cmd_last set; every
//   request of a command carries its length in cmd_length.
//   cfg_we/cfg_wdata load the idle timeout in ticks; it is 100 after reset.
// Timing:
//   An ordinary byte is written to the line store and produces nothing. The line
//   feed that completes a command of N bytes yields N + 1 output requests; the
//   first passes through the command queue, the store read and the output buffer,
//   and the rest follow at one per cycle while cmd.ready stays high, paced by the
//   single read port of the line store. rx.ready stays low from the cycle after
//   that line feed until the last byte has been read from the store.
// Reset:
//   Clears the held count, the previous tick and all queued output; the line
//   store needs no clearing. When cmd.ready is low the two-entry output buffer
//   fills, reading stops, and rx stays stalled until the read-out completes.
// ----------------------------------------------------------------------------
module crlf_command_line_framer_unit #(
    parameter int LINE_DEPTH = clf_pkg::LINE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    clf_rx_if.sink                         rx,
    clf_cmd_if.source                      cmd,
    input  logic                           cfg_we,
    input  logic [clf_pkg::TIMEOUT_W-1:0]  cfg_wdata
);

    localparam int AW = $clog2(LINE_DEPTH);

    clf_pkg::cmd_req_t               req;
    logic                            back_busy;
    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [clf_pkg::BYTE_W-1:0]      ram_wdata;
    logic                            ram_re;
    logic [AW-1:0]                   ram_raddr;
    logic [clf_pkg::BYTE_W-1:0]      ram_rdata;

    clf_front #(
        .LINE_DEPTH (LINE_DEPTH),
        .AW         (AW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .back_busy  (back_busy),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .req        (req)
    );

    clf_ram #(
        .WIDTH (clf_pkg::BYTE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    clf_back #(
        .LINE_DEPTH (LINE_DEPTH),
        .AW         (AW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .busy       (back_busy),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .cmd        (cmd)
    );

endmodule

// ===== verif/tb_crlf_command_line_framer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CR LF command line framer testbench
// Sends received bytes with arrival ticks and predicts every command byte and
// terminator. The stimulus covers idle timeouts, tick wrap, empty and maximum
// commands, dropped full lines, store overflow and a long output stall. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module tb_crlf_command_line_framer_unit;

    localparam int DEPTH       = clf_pkg::LINE_DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;

    class command_framer_check;
        logic [clf_pkg::BYTE_W-1:0]    line_mem [DEPTH];
        int unsigned                   held;
        logic [clf_pkg::TICK_W-1:0]    last_tick;
        logic [clf_pkg::TIMEOUT_W-1:0] idle_limit;
        clf_pkg::cmd_item_t            cmd_due [$];
        int unsigned                   mismatches;

        function new();
            held       = 0;
            last_tick  = '0;
            idle_limit = clf_pkg::TIMEOUT_RESET;
            mismatches = 0;
        endfunction

        function void set_timeout(logic [clf_pkg::TIMEOUT_W-1:0] v);
            idle_limit = v;
        endfunction

        function void take_rx_byte(logic [clf_pkg::BYTE_W-1:0] b,
                                   logic [clf_pkg::TICK_W-1:0] t);
            logic [clf_pkg::TICK_W-1:0] gap;
            int unsigned                len;
            clf_pkg::cmd_item_t         item;
            gap = t - last_tick;
            if (held > 0 && gap > {16'd0, idle_limit})
                held = 0;
            last_tick = t;
            if (held > 0 && b == clf_pkg::CH_LF && line_mem[held - 1] == clf_pkg::CH_CR)
            begin
                // A line that has all but filled the store is thrown away.
                if (held + 1 < DEPTH - 1)
                begin
                    len = held - 1;
                    for (int i = 0; i < len; i++)
                    begin
                        item.cmd_byte   = line_mem[i];
                        item.cmd_last   = 1'b0;
                        item.cmd_length = clf_pkg::CMD_LEN_W'(len);
                        cmd_due.push_back(item);
                    end
                    item.cmd_byte   = clf_pkg::CH_NUL;
                    item.cmd_last   = 1'b1;
                    item.cmd_length = clf_pkg::CMD_LEN_W'(len);
                    cmd_due.push_back(item);
                end
                held = 0;
            end
            else
            begin
                line_mem[held] = b;
                held++;
                if (held >= DEPTH - 1)
                    held = 0;
            end
        endfunction

        function void match_cmd_item(clf_pkg::cmd_item_t got);
            clf_pkg::cmd_item_t want;
            if (cmd_due.size() == 0)
            begin
                $display("%0t: unexpected request byte=%02h last=%0b length=%0d",
                         $time, got.cmd_byte, got.cmd_last, got.cmd_length);
                mismatches++;
                return;
            end
            want = cmd_due.pop_front();
            if (got.cmd_byte !== want.cmd_byte)
            begin
                $display("%0t: cmd_byte expected %02h actual %02h",
                         $time, want.cmd_byte, got.cmd_byte);
                mismatches++;
            end
            if (got.cmd_last !== want.cmd_last)
            begin
                $display("%0t: cmd_last expected %0b actual %0b",
                         $time, want.cmd_last, got.cmd_last);
                mismatches++;
            end
            if (got.cmd_length !== want.cmd_length)
            begin
                $display("%0t: cmd_length expected %0d actual %0d",
                         $time, want.cmd_length, got.cmd_length);
                mismatches++;
            end
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [clf_pkg::TIMEOUT_W-1:0] cfg_wdata;

    bit                            calm;
    bit                            stall_req;
    logic [clf_pkg::TICK_W-1:0]    tick_now;
    logic [clf_pkg::TIMEOUT_W-1:0] idle_cfg;
    int unsigned                   items_sent;
    int unsigned                   quiet_cycles = 0;
    command_framer_check           framer = new();

    clf_rx_if  rx_ch ();
    clf_cmd_if cmd_ch ();

    crlf_command_line_framer_unit #(.LINE_DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .cmd       (cmd_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watches both channels, feeds the checker and guards against a hang.
    always @(posedge clk)
    begin
        clf_pkg::cmd_item_t got;
        if (rst_n === 1'b1)
        begin
            if (rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1)
                framer.take_rx_byte(rx_ch.rx_byte, rx_ch.now_tick);
            if (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1)
            begin
                got.cmd_byte   = cmd_ch.cmd_byte;
                got.cmd_last   = cmd_ch.cmd_last;
                got.cmd_length = cmd_ch.cmd_length;
                framer.match_cmd_item(got);
            end
            if ((rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) ||
                (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_crlf_command_line_framer_unit: errors");
                $finish;
            end
        end
    end

    // Output side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        cmd_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_req)
            begin
                stall_req = 1'b0;
                cmd_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
                cmd_ch.ready <= (calm || $urandom_range(99) >= 14);
        end
    end

    task automatic send_at(input logic [clf_pkg::BYTE_W-1:0] b,
                           input logic [clf_pkg::TICK_W-1:0] t);
        tick_now = t;
        rx_ch.valid    <= 1'b1;
        rx_ch.rx_byte  <= b;
        rx_ch.now_tick <= t;
        do
            @(posedge clk);
        while (rx_ch.ready !== 1'b1);
        items_sent++;
        if (!calm && $urandom_range(99) < 14)
        begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // With keep set the gap never exceeds the timeout, so the line survives.
    task automatic send_byte(input logic [clf_pkg::BYTE_W-1:0] b, input bit keep);
        logic [clf_pkg::TICK_W-1:0] gap;
        int unsigned                r;
        r = $urandom_range(99);
        if (!keep && r < 8)
            gap = clf_pkg::TICK_W'(idle_cfg) + 1 + $urandom_range(0, 5000);
        else if (!keep && r < 10)
            gap = $urandom;
        else
            gap = $urandom_range(0, idle_cfg);
        send_at(b, tick_now + gap);
    endtask

    task automatic send_line(input int len, input bit crlf, input bit keep);
        logic [clf_pkg::BYTE_W-1:0] b;
        for (int i = 0; i < len; i++)
        begin
            b = clf_pkg::BYTE_W'($urandom_range(0, 255));
            if (keep && b == clf_pkg::CH_LF)
                b = 8'h4C;
            send_byte(b, keep);
        end
        if (crlf)
        begin
            send_byte(clf_pkg::CH_CR, keep);
            send_byte(clf_pkg::CH_LF, keep);
        end
    endtask

    task automatic random_traffic(input int unsigned budget);
        int unsigned                start;
        int unsigned                r;
        logic [clf_pkg::BYTE_W-1:0] b;
        start = items_sent;
        while (items_sent - start < budget)
        begin
            r = $urandom_range(99);
            if (r < 72)
                send_line($urandom_range(0, 14), 1'b1, 1'b0);
            else if (r < 84)
                send_line($urandom_range(1, 6), 1'b0, 1'b0);
            else if (r < 92)
            begin
                // A carriage return followed by something other than a line feed.
                b = clf_pkg::BYTE_W'($urandom_range(0, 255));
                if (b == clf_pkg::CH_LF)
                    b = clf_pkg::CH_CR;
                send_byte(clf_pkg::CH_CR, 1'b0);
                send_byte(b, 1'b0);
            end
            else if (r < 96)
                send_byte(clf_pkg::CH_LF, 1'b0);
            else
                send_byte(clf_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic write_timeout(input logic [clf_pkg::TIMEOUT_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        idle_cfg = v;
        framer.set_timeout(v);
    endtask

    task automatic drain();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (framer.cmd_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        rx_ch.valid    <= 1'b0;
        rx_ch.rx_byte  <= '0;
        rx_ch.now_tick <= '0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        calm       = 1'b0;
        stall_req  = 1'b0;
        tick_now   = '0;
        items_sent = 0;
        idle_cfg   = clf_pkg::TIMEOUT_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A line feed on an empty store is kept as data.
        send_at(clf_pkg::CH_LF, 32'h0000_0000);
        send_at(clf_pkg::CH_CR, 32'h0000_0001);
        send_at(clf_pkg::CH_LF, 32'h0000_0002);
        // Bare CR LF gives only the terminator.
        send_at(clf_pkg::CH_CR, 32'h0000_0003);
        send_at(clf_pkg::CH_LF, 32'h0000_0004);
        send_at(8'h00, 32'h0000_0005);
        send_at(8'hFF, 32'h0000_0006);
        send_at(clf_pkg::CH_CR, 32'h0000_0007);
        send_at(clf_pkg::CH_LF, 32'h0000_0008);
        // One tick beyond the timeout discards the held byte.
        send_at(8'h41, 32'h0000_1000);
        send_at(clf_pkg::CH_CR, 32'h0000_1065);
        send_at(clf_pkg::CH_LF, 32'h0000_1066);
        // A gap of exactly the timeout keeps it.
        send_at(8'h42, 32'h0000_2000);
        send_at(clf_pkg::CH_CR, 32'h0000_2064);
        send_at(clf_pkg::CH_LF, 32'h0000_2064);
        // The tick difference is taken across the wrap.
        send_at(8'h43, 32'hFFFF_FFFF);
        send_at(clf_pkg::CH_CR, 32'h0000_0001);
        send_at(clf_pkg::CH_LF, 32'h0000_0002);
        send_at(clf_pkg::CH_CR, 32'h0000_0003);
        send_at(clf_pkg::CH_CR, 32'h0000_0004);
        send_at(clf_pkg::CH_LF, 32'h0000_0005);
        drain();

        // Largest command, a line dropped as too full, and a store overflow.
        write_timeout(16'hFFFF);
        calm = 1'b1;
        tick_now = 32'hFFFF_F000;
        send_line(DEPTH - 4, 1'b1, 1'b1);
        send_line(DEPTH - 3, 1'b1, 1'b1);
        send_line(DEPTH - 2, 1'b1, 1'b1);
        drain();
        calm = 1'b0;

        write_timeout(16'd0);
        random_traffic(8);
        drain();

        // The output holds off while input keeps coming, so the block backs up.
        write_timeout(16'd1000);
        stall_req = 1'b1;
        send_line(12, 1'b1, 1'b1);
        random_traffic(6);
        drain();

        write_timeout(clf_pkg::TIMEOUT_W'($urandom_range(1, 65534)));
        tick_now = $urandom;
        random_traffic(8);
        drain();

        write_timeout(clf_pkg::TIMEOUT_RESET);
        random_traffic(6);
        drain();

        if (framer.mismatches == 0 && framer.cmd_due.size() == 0)
            $display("tb_crlf_command_line_framer_unit: clean");
        else
            $display("tb_crlf_command_line_framer_unit: errors");
        $finish;
    end

endmodule
